// ===== rtl/sxd_pkg.sv =====
package sxd_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 8192;
  localparam int QUEUE_DEPTH_DEF     = 2;
  localparam int CFG_ADDR_W          = 3;
  localparam int OUT_DATA_W          = 72;

  localparam logic [7:0] BYTE_SOX = 8'hF0;
  localparam logic [7:0] BYTE_EOX = 8'hF7;

  localparam logic [CFG_ADDR_W-1:0] REG_DEVICE_MODE = 3'd0;

  typedef enum logic [2:0] {
    KIND_REG       = 3'd0,
    KIND_RAW       = 3'd1,
    KIND_OK        = 3'd2,
    KIND_MALFORMED = 3'd3,
    KIND_BADENC    = 3'd4,
    KIND_DROPPED   = 3'd5
  } sxd_kind_t;

  typedef struct packed {
    sxd_kind_t   kind;
    logic [6:0]  sub_id;
    logic [31:0] word;
  } sxd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sxd_q_stat_t;

  // Expected frame header, indexed by byte position.
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'hF0;
      3'd1:    v = 8'h00;
      3'd2:    v = 8'h20;
      3'd3:    v = 8'h0D;
      3'd4:    v = 8'h10;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sxd_front.sv =====
module sxd_front #(
  parameter int MAX_FRAME_BYTES = sxd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_acc,
  input  logic [7:0]         stream_byte,
  input  logic               device_mode,
  output logic               push,
  output sxd_pkg::sxd_entry_t entry
);
  import sxd_pkg::*;

  localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FRAME_BYTES);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [2:0]    grp_r, grp_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [6:0]    sub_r, sub_nxt;
  logic          hdr_bad_r, hdr_bad_nxt;
  logic          enc_bad_r, enc_bad_nxt;
  logic          over_r, over_nxt;

  logic [31:0] acc_or;
  logic [6:0]  b7;

  assign b7 = stream_byte[6:0];

  always_comb begin
    case (grp_r)
      3'd0:    acc_or = acc_r | {25'd0, b7};
      3'd1:    acc_or = acc_r | {18'd0, b7, 7'd0};
      3'd2:    acc_or = acc_r | {11'd0, b7, 14'd0};
      3'd3:    acc_or = acc_r | {4'd0, b7, 21'd0};
      default: acc_or = acc_r | {b7[3:0], 28'd0};
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    grp_nxt     = grp_r;
    acc_nxt     = acc_r;
    sub_nxt     = sub_r;
    hdr_bad_nxt = hdr_bad_r;
    enc_bad_nxt = enc_bad_r;
    over_nxt    = over_r;
    push        = 1'b0;
    entry.kind   = KIND_DROPPED;
    entry.sub_id = sub_r;
    entry.word   = 32'd0;

    if (stream_byte == BYTE_SOX) begin
      // drop any frame in progress and restart
      push        = (cnt_r != '0) && !over_r;
      cnt_nxt     = CW'(1);
      grp_nxt     = 3'd0;
      acc_nxt     = 32'd0;
      sub_nxt     = 7'd0;
      hdr_bad_nxt = 1'b0;
      enc_bad_nxt = 1'b0;
      over_nxt    = 1'b0;
    end else if (over_r) begin
      if (stream_byte == BYTE_EOX) begin
        cnt_nxt  = '0;
        grp_nxt  = 3'd0;
        acc_nxt  = 32'd0;
        sub_nxt  = 7'd0;
        hdr_bad_nxt = 1'b0;
        enc_bad_nxt = 1'b0;
        over_nxt = 1'b0;
      end
    end else if (cnt_r >= MAX_CNT) begin
      push = 1'b1;
      if (stream_byte == BYTE_EOX) begin
        cnt_nxt  = '0;
        grp_nxt  = 3'd0;
        acc_nxt  = 32'd0;
        sub_nxt  = 7'd0;
        hdr_bad_nxt = 1'b0;
        enc_bad_nxt = 1'b0;
      end else begin
        over_nxt = 1'b1;
      end
    end else if (stream_byte == BYTE_EOX) begin
      push = 1'b1;
      if (hdr_bad_r || cnt_r < CW'(6) || grp_r != 3'd0) begin
        entry.kind = KIND_MALFORMED;
      end else if (enc_bad_r) begin
        entry.kind = KIND_BADENC;
      end else begin
        entry.kind = KIND_OK;
      end
      cnt_nxt     = '0;
      grp_nxt     = 3'd0;
      acc_nxt     = 32'd0;
      sub_nxt     = 7'd0;
      hdr_bad_nxt = 1'b0;
      enc_bad_nxt = 1'b0;
    end else begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r < CW'(5)) begin
        if (stream_byte != hdr_byte(cnt_r[2:0])) begin
          hdr_bad_nxt = 1'b1;
        end
      end else if (cnt_r == CW'(5)) begin
        sub_nxt = b7;
      end else if (grp_r != 3'd4) begin
        acc_nxt = acc_or;
        grp_nxt = grp_r + 3'd1;
      end else begin
        // fifth byte closes the group
        acc_nxt = 32'd0;
        grp_nxt = 3'd0;
        if (!hdr_bad_r) begin
          if (sub_r != 7'd0 || device_mode) begin
            if (!enc_bad_r) begin
              push = 1'b1;
              if (stream_byte[7:4] != 4'd0) begin
                enc_bad_nxt = 1'b1;
                entry.kind  = KIND_BADENC;
              end else begin
                entry.kind = KIND_RAW;
                entry.word = acc_or;
              end
            end
          end else begin
            push       = 1'b1;
            entry.kind = KIND_REG;
            entry.word = acc_or;
          end
        end
      end
    end

    if (!byte_acc) begin
      push = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      grp_r     <= 3'd0;
      acc_r     <= 32'd0;
      sub_r     <= 7'd0;
      hdr_bad_r <= 1'b0;
      enc_bad_r <= 1'b0;
      over_r    <= 1'b0;
    end else if (byte_acc) begin
      cnt_r     <= cnt_nxt;
      grp_r     <= grp_nxt;
      acc_r     <= acc_nxt;
      sub_r     <= sub_nxt;
      hdr_bad_r <= hdr_bad_nxt;
      enc_bad_r <= enc_bad_nxt;
      over_r    <= over_nxt;
    end
  end

endmodule

// ===== rtl/sxd_queue.sv =====
module sxd_queue #(
  parameter int QUEUE_DEPTH = sxd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sxd_pkg::sxd_entry_t push_entry,
  input  logic                pop,
  output sxd_pkg::sxd_entry_t pop_entry,
  output sxd_pkg::sxd_q_stat_t stat
);
  import sxd_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  sxd_entry_t mem [QUEUE_DEPTH];

  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] num_r, num_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (num_r == NW'(QUEUE_DEPTH));
  assign stat.empty = (num_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_entry  = mem[rd_ptr_r];

  always_comb begin
    num_nxt = num_r;
    if (do_push && !do_pop) begin
      num_nxt = num_r + NW'(1);
    end else if (do_pop && !do_push) begin
      num_nxt = num_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      num_r    <= '0;
    end else begin
      num_r <= num_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
      end
    end
  end

endmodule

// ===== rtl/sxd_back.sv =====
module sxd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sxd_pkg::sxd_q_stat_t                 q_stat,
  input  sxd_pkg::sxd_entry_t                  q_entry,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sxd_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic [2:0]                           out_tuser
);
  import sxd_pkg::*;

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r, data_nxt;
  logic [2:0]            user_r;
  logic [14:0]           reg_index;
  logic [15:0]           reg_value;
  logic [31:0]           raw_word;
  logic                  parity_error;

  // Refill the output register whenever it is empty or being taken.
  assign q_pop = !q_stat.empty && (!valid_r || out_tready);

  always_comb begin
    reg_index    = 15'd0;
    reg_value    = 16'd0;
    raw_word     = 32'd0;
    parity_error = 1'b0;
    case (q_entry.kind)
      KIND_REG: begin
        reg_index    = q_entry.word[30:16];
        reg_value    = q_entry.word[15:0];
        raw_word     = q_entry.word;
        parity_error = ~(^q_entry.word);
      end
      KIND_RAW: begin
        raw_word = q_entry.word;
      end
      default: begin
        raw_word = 32'd0;
      end
    endcase
    data_nxt = {1'b0, parity_error, raw_word, reg_value, reg_index, q_entry.sub_id};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
      user_r <= q_entry.kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// ===== rtl/sysex_register_frame_decoder.sv =====
// SysEx register frame decoder.
// Input stream: one byte per item on in_tdata; an item is taken when in_tvalid
// and in_tready are both high. Bytes F0 00 20 0D 10, a sub-id, five-byte groups
// of 7-bit data and a closing F7 form a frame.
// Output stream: one result item per completed word, per frame close and per
// dropped frame; out_tuser carries the result kind, out_tdata the payload.
// Throughput: one byte per cycle while the queue is not full. The parser
// decides each byte in the cycle it is taken and writes any result into a
// two-entry queue; the output stage pulls from that queue into the output
// register, so a result is registered in the queue and then in the output
// register before it shows on out_tvalid.
// Stall: when out_tready is low the output register holds, the queue fills,
// and in_tready drops only once the queue is full.
// Reset: rst_n (synchronous, active low) returns the parser to idle, empties
// the queue and output register, and sets device_mode to register decoding.
// Config: device_mode at APB address 0, bit 0; write it only while idle.
module sysex_register_frame_decoder #(
  parameter int MAX_FRAME_BYTES = sxd_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = sxd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,    // [7:0] stream_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [6:0] sub_id, [21:7] reg_index, [37:22] reg_value, [69:38] raw_word,
  // [70] parity_error, [71] zero
  output logic [sxd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [2:0]                         out_tuser,   // [2:0] result_kind
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [sxd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import sxd_pkg::*;

  logic        device_mode_r;
  logic        byte_acc;
  logic        push;
  logic        q_pop;
  sxd_entry_t  push_entry;
  sxd_entry_t  q_entry;
  sxd_q_stat_t q_stat;
  logic        reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1] == REG_DEVICE_MODE[CFG_ADDR_W-1]);
  assign cfg_prdata = reg_sel ? {31'd0, device_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      device_mode_r <= cfg_pwdata[0];
    end
  end

  assign in_tready = !q_stat.full;
  assign byte_acc  = in_tvalid && in_tready;

  sxd_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_acc    (byte_acc),
    .stream_byte (in_tdata),
    .device_mode (device_mode_r),
    .push        (push),
    .entry       (push_entry)
  );

  sxd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (q_entry),
    .stat       (q_stat)
  );

  sxd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  a_q_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= KIND_DROPPED))
    else $error("result kind out of range");

  a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REG) |->
      (out_tdata[21:7] == out_tdata[68:54] && out_tdata[37:22] == out_tdata[53:38]))
    else $error("register fields disagree with raw word");

  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_REG && out_tuser != KIND_RAW) |->
      (out_tdata[70:7] == 64'd0))
    else $error("status item carries word data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("reset left output valid or input stalled");
`endif

endmodule

// ===== dv/sysex_register_frame_decoder_tb.sv =====
`timescale 1ns / 100ps

module sysex_register_frame_decoder_tb;
  import sxd_pkg::*;

  localparam int MAX_BYTES      = MAX_FRAME_BYTES_DEF;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_BYTES    = 450;
  // frame header, first byte in the low bits
  localparam logic [39:0] HEADER = 40'h10_0D_20_00_F0;

  typedef struct packed {
    sxd_kind_t   kind;
    logic [6:0]  sub_id;
    logic [14:0] reg_index;
    logic [15:0] reg_value;
    logic [31:0] raw_word;
    logic        parity_error;
  } result_t;

  class sysex_scoreboard;
    logic [13:0] frame_bytes;
    logic [2:0]  group_pos;
    logic [31:0] word_acc;
    logic [6:0]  sub_id;
    bit          hdr_bad;
    bit          enc_bad;
    bit          too_long;
    bit          raw_mode;
    result_t     expected_results[$];
    int          errors;

    function new();
      clear_frame();
      raw_mode = 1'b0;
      errors = 0;
    endfunction

    function void clear_frame();
      frame_bytes = '0;
      group_pos = '0;
      word_acc = '0;
      sub_id = '0;
      hdr_bad = 1'b0;
      enc_bad = 1'b0;
      too_long = 1'b0;
    endfunction

    function void push_status(sxd_kind_t k);
      result_t r;
      r = '0;
      r.kind = k;
      r.sub_id = sub_id;
      expected_results.push_back(r);
    endfunction

    // Advance the frame state by one accepted byte and queue any result it causes.
    function void decode_byte(logic [7:0] b);
      logic [13:0] pos;
      logic [31:0] chunk;
      logic [31:0] w;
      result_t     r;
      if (b == BYTE_SOX) begin
        if (frame_bytes != 0 && !too_long) push_status(KIND_DROPPED);
        clear_frame();
        frame_bytes = 14'd1;
        return;
      end
      if (too_long) begin
        if (b == BYTE_EOX) clear_frame();
        return;
      end
      if (frame_bytes >= MAX_BYTES) begin
        push_status(KIND_DROPPED);
        if (b == BYTE_EOX) clear_frame();
        else too_long = 1'b1;
        return;
      end
      if (b == BYTE_EOX) begin
        if (hdr_bad || frame_bytes < 6 || group_pos != 0) push_status(KIND_MALFORMED);
        else if (enc_bad) push_status(KIND_BADENC);
        else push_status(KIND_OK);
        clear_frame();
        return;
      end
      pos = frame_bytes;
      frame_bytes = frame_bytes + 14'd1;
      if (pos < 5) begin
        if (b != HEADER[8*pos +: 8]) hdr_bad = 1'b1;
        return;
      end
      if (pos == 5) begin
        sub_id = b[6:0];
        return;
      end
      chunk = {25'd0, b[6:0]};
      word_acc = word_acc | (chunk << (7 * group_pos));
      group_pos = group_pos + 3'd1;
      if (group_pos < 5) return;
      group_pos = '0;
      w = word_acc;
      word_acc = '0;
      if (hdr_bad) return;
      if (sub_id != 0 || raw_mode) begin
        if (enc_bad) return;
        if (b[7:4] != 0) begin
          enc_bad = 1'b1;
          push_status(KIND_BADENC);
          return;
        end
        r = '0;
        r.kind = KIND_RAW;
        r.sub_id = sub_id;
        r.raw_word = w;
        expected_results.push_back(r);
        return;
      end
      r.kind = KIND_REG;
      r.sub_id = sub_id;
      r.reg_index = w[30:16];
      r.reg_value = w[15:0];
      r.raw_word = w;
      r.parity_error = ~^w;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [OUT_DATA_W-1:0] d);
      result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0d data %h",
                 $time, kind, d);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      compare_field("result_kind", 32'(e.kind), 32'(kind));
      compare_field("sub_id", 32'(e.sub_id), 32'(d[6:0]));
      compare_field("reg_index", 32'(e.reg_index), 32'(d[21:7]));
      compare_field("reg_value", 32'(e.reg_value), 32'(d[37:22]));
      compare_field("raw_word", e.raw_word, d[69:38]);
      compare_field("parity_error", 32'(e.parity_error), 32'(d[70]));
      compare_field("pad", 32'd0, 32'(d[71]));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;    // [7:0] stream_byte
  logic                  out_tvalid;
  logic                  out_tready;
  // [6:0] sub_id, [21:7] reg_index, [37:22] reg_value, [69:38] raw_word,
  // [70] parity_error, [71] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;   // [2:0] result_kind
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  sysex_scoreboard sb = new();
  logic [7:0]      byte_q[$];
  bit              tx_steady;
  bit              rx_steady;
  int              hold_req_count;
  int              hold_served;
  int              idle_cycles;

  sysex_register_frame_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) sb.decode_byte(in_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    out_tready = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_req_count) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_served++;
      end else begin
        out_tready <= rx_steady || ($urandom_range(99) >= 33);
      end
    end
  end

  function automatic logic [7:0] data_byte();
    logic [7:0] v;
    if ($urandom_range(99) < 10) v = 8'($urandom_range(128, 255));
    else v = 8'($urandom_range(0, 127));
    // keep frame markers out of the payload
    if (v == BYTE_SOX || v == BYTE_EOX) v = v & 8'h7F;
    return v;
  endfunction

  function automatic void add_header(int n);
    for (int i = 0; i < n; i++) byte_q.push_back(HEADER[8*i +: 8]);
  endfunction

  function automatic void add_sub_id();
    byte_q.push_back(($urandom_range(1) == 0) ? 8'h00 : data_byte());
  endfunction

  function automatic void add_groups(int n);
    for (int g = 0; g < n; g++) begin
      repeat (4) byte_q.push_back(data_byte());
      // mostly a clean fifth byte, sometimes one that fails the raw check
      if ($urandom_range(99) < 80) byte_q.push_back(8'($urandom_range(0, 15)));
      else byte_q.push_back(data_byte());
    end
  endfunction

  function automatic void add_frame();
    int pick;
    int n;
    int idx;
    pick = $urandom_range(99);
    n = $urandom_range(0, 4);
    if (pick < 70) begin
      add_header(5);
      add_sub_id();
      add_groups(n);
      if ($urandom_range(9) != 0) byte_q.push_back(BYTE_EOX);
    end else if (pick < 80) begin
      add_header(5);
      idx = byte_q.size() - 5 + $urandom_range(1, 4);
      byte_q[idx] = 8'($urandom_range(0, 255));
      add_sub_id();
      add_groups(n);
      byte_q.push_back(BYTE_EOX);
    end else if (pick < 87) begin
      add_header(5);
      add_sub_id();
      add_groups(n);
      repeat ($urandom_range(1, 4)) byte_q.push_back(data_byte());
      byte_q.push_back(BYTE_EOX);
    end else if (pick < 92) begin
      add_header($urandom_range(1, 5));
      byte_q.push_back(BYTE_EOX);
    end else begin
      repeat ($urandom_range(1, 6)) byte_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!tx_steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_queue();
    @(negedge clk);
    foreach (byte_q[i]) send_byte(byte_q[i]);
    in_tvalid <= 1'b0;
    byte_q.delete();
  endtask

  task automatic wait_drain();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write device_mode, then read it back.
  task automatic program_mode(input bit mode);
    logic [31:0] rd;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_DEVICE_MODE;
    cfg_pwdata <= {31'd0, mode};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.raw_mode = mode;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    if (rd !== {31'd0, mode}) begin
      $display("%0t: device_mode readback mismatch: expected %h, got %h",
               $time, {31'd0, mode}, rd);
      sb.errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    int base;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req_count = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_mode(1'b0);
    // all-ones and all-zero register words, lone end marker, stray byte while
    // idle, bad fifth byte on a raw word, start marker inside a frame
    byte_q = '{8'hF0, 8'h00, 8'h20, 8'h0D, 8'h10, 8'h00,
               8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
               8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF7,
               8'hF7,
               8'h55, 8'hF7,
               8'hF0, 8'h00, 8'h20, 8'h0D, 8'h10, 8'h7F,
               8'h01, 8'h02, 8'h03, 8'h04, 8'h80, 8'hF0};
    send_queue();
    wait_drain();

    for (int phase = 1; phase <= 4; phase++) begin
      program_mode(phase % 2 == 1);
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      while (byte_q.size() < PHASE_BYTES / 2) add_frame();
      base = byte_q.size();
      while (byte_q.size() - base < PHASE_BYTES / 2) add_frame();
      // hold the output off while bytes keep coming, so the input stalls
      if (phase == 1) hold_req_count++;
      send_queue();
      wait_drain();
    end

    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
